### design/rvb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rvb_pkg;

   // default sizes
   localparam int COMB_DEPTH_DEF    = 8192;
   localparam int ALLPASS_DEPTH_DEF = 512;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int LINE_BITS_DEF     = 20;

   localparam int NUM_COMB = 4;
   localparam int NUM_AP   = 3;

   // register widths
   localparam int LEVEL_W    = 7;
   localparam int CLEN_W     = 14;
   localparam int ALEN_W     = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 14;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_LEVEL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COMB0 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COMB3 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_AP0   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_AP2   = 3'd7;

   // q0.16 gains, one extra bit so that unity fits
   localparam int COEF_W      = 16;
   localparam int GAIN_W      = 17;
   localparam int ROUND_SHIFT = 16;
   localparam logic [GAIN_W-1:0] RND_HALF = 17'd32768;

   localparam logic [COEF_W-1:0] COMB_GAIN [NUM_COMB] = '{16'd52756, 16'd54198,
                                                          16'd51315, 16'd50070};
   localparam logic [COEF_W-1:0] AP_GAIN = 16'd45875;

   localparam logic [CLEN_W-1:0] COMB_LEN_RST [NUM_COMB] = '{14'd3460, 14'd2988,
                                                             14'd3882, 14'd4312};
   localparam logic [ALEN_W-1:0] AP_LEN_RST [NUM_AP] = '{10'd480, 10'd161, 10'd46};

   // round(n * 65536 / 127) = 516 n + floor((4 n + 63) / 127)
   function automatic logic [GAIN_W-1:0] level_gain(input logic [LEVEL_W-1:0] n);
      logic [9:0] t;
      logic [2:0] q;
      begin
         t = {1'b0, n, 2'b00} + 10'd63;
         q = 3'(t >= 10'd127) + 3'(t >= 10'd254) + 3'(t >= 10'd381) + 3'(t >= 10'd508);
         return GAIN_W'(n) * 17'd516 + GAIN_W'(q);
      end
   endfunction

endpackage
`default_nettype wire

### design/rvb_comb.sv
`timescale 1ns / 1ps
`default_nettype none
module rvb_comb #(
   parameter int DEPTH       = rvb_pkg::COMB_DEPTH_DEF,
   parameter int SAMPLE_BITS = rvb_pkg::SAMPLE_BITS_DEF,
   parameter int LINE_BITS   = rvb_pkg::LINE_BITS_DEF,
   localparam int PW         = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [SAMPLE_BITS-1:0] dry,
   input  logic [rvb_pkg::CLEN_W-1:0]    len,
   input  logic [rvb_pkg::COEF_W-1:0]    gain,
   input  logic                          clr_en,
   input  logic [PW-1:0]                 clr_addr,
   output logic signed [LINE_BITS-1:0]   rb_out
);

   localparam int SW  = ((LINE_BITS > SAMPLE_BITS) ? LINE_BITS : SAMPLE_BITS) + 2;
   localparam int PRW = LINE_BITS + rvb_pkg::GAIN_W;
   localparam logic signed [SW-1:0] LMAX = {{(SW-LINE_BITS+1){1'b0}}, {(LINE_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] LMIN = {{(SW-LINE_BITS+1){1'b1}}, {(LINE_BITS-1){1'b0}}};

   logic signed [LINE_BITS-1:0]   mem [DEPTH];
   logic [PW-1:0]                 pos_ff, pos_in, a1_ff, a2_ff;
   logic [PW:0]                   len_eff, pos_inc;
   logic                          v1_ff, v2_ff, hit1_ff, hit2_ff;
   logic signed [LINE_BITS-1:0]   rd_ff, fwd_ff, rb, rb2_ff, wval;
   logic signed [SAMPLE_BITS-1:0] d1_ff, d2_ff;
   logic signed [PRW-1:0]         prod, prod_ff, prod_rnd;
   logic signed [LINE_BITS:0]     rnd;
   logic signed [SW-1:0]          wsum;

   always_comb begin
      if (len == '0) begin
         len_eff = (PW+1)'(1);
      end else if (32'(len) > 32'(DEPTH)) begin
         len_eff = (PW+1)'(DEPTH);
      end else begin
         len_eff = (PW+1)'(len);
      end
   end

   assign pos_inc = {1'b0, pos_ff} + (PW+1)'(1);
   assign pos_in  = (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];

   // newest pending write wins over the memory read
   assign rb   = hit1_ff ? wval : (hit2_ff ? fwd_ff : rd_ff);
   assign prod = rb * $signed({1'b0, gain});

   assign prod_rnd = prod_ff + PRW'(rvb_pkg::RND_HALF);
   assign rnd      = (LINE_BITS+1)'(prod_rnd >>> rvb_pkg::ROUND_SHIFT);
   assign wsum     = SW'(rnd) + SW'(d2_ff);
   assign wval     = (wsum > LMAX) ? LINE_BITS'(LMAX) :
                     (wsum < LMIN) ? LINE_BITS'(LMIN) : LINE_BITS'(wsum);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         hit1_ff <= 1'b0;
         hit2_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         hit1_ff <= in_valid && v1_ff && (a1_ff == pos_ff);
         hit2_ff <= in_valid && v2_ff && (a2_ff == pos_ff);
         if (in_valid) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= pos_ff;
         a2_ff   <= a1_ff;
         d1_ff   <= dry;
         d2_ff   <= d1_ff;
         fwd_ff  <= wval;
         prod_ff <= prod;
         rb2_ff  <= rb;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= mem[pos_ff];
      end
      if (clr_en) begin
         mem[clr_addr] <= '0;
      end else if (en && v2_ff) begin
         mem[a2_ff] <= wval;
      end
   end

   assign rb_out = rb2_ff;

endmodule
`default_nettype wire

### design/rvb_allpass.sv
`timescale 1ns / 1ps
`default_nettype none
module rvb_allpass #(
   parameter int DEPTH     = rvb_pkg::ALLPASS_DEPTH_DEF,
   parameter int LINE_BITS = rvb_pkg::LINE_BITS_DEF,
   localparam int PW       = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [LINE_BITS-1:0] x,
   input  logic [rvb_pkg::ALEN_W-1:0]  len,
   input  logic                        clr_en,
   input  logic [PW-1:0]               clr_addr,
   output logic signed [LINE_BITS-1:0] r_out
);

   localparam int SW  = LINE_BITS + 2;
   localparam int PRW = LINE_BITS + rvb_pkg::GAIN_W;
   localparam logic signed [SW-1:0] LMAX = {3'b000, {(LINE_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] LMIN = {3'b111, {(LINE_BITS-1){1'b0}}};
   localparam logic signed [rvb_pkg::GAIN_W-1:0] G = {1'b0, rvb_pkg::AP_GAIN};

   logic signed [LINE_BITS-1:0] mem [DEPTH];
   logic [PW-1:0]               pos_ff, pos_in, a1_ff, a2_ff;
   logic [PW:0]                 len_eff, pos_inc;
   logic                        v1_ff, v2_ff, hit1_ff, hit2_ff;
   logic signed [LINE_BITS-1:0] rd_ff, fwd_ff, rb, r, r2_ff, x1_ff, x2_ff, wval;
   logic signed [PRW-1:0]       m_ff, m_rnd, p, p_rnd;
   logic signed [LINE_BITS:0]   mr, pr;
   logic signed [SW-1:0]        diff, wsum;

   always_comb begin
      if (len == '0) begin
         len_eff = (PW+1)'(1);
      end else if (32'(len) > 32'(DEPTH)) begin
         len_eff = (PW+1)'(DEPTH);
      end else begin
         len_eff = (PW+1)'(len);
      end
   end

   assign pos_inc = {1'b0, pos_ff} + (PW+1)'(1);
   assign pos_in  = (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];

   // stage one: feedforward term against the delayed value
   assign rb    = hit1_ff ? wval : (hit2_ff ? fwd_ff : rd_ff);
   assign m_rnd = m_ff + PRW'(rvb_pkg::RND_HALF);
   assign mr    = (LINE_BITS+1)'(m_rnd >>> rvb_pkg::ROUND_SHIFT);
   assign diff  = SW'(rb) - SW'(mr);
   assign r     = (diff > LMAX) ? LINE_BITS'(LMAX) :
                  (diff < LMIN) ? LINE_BITS'(LMIN) : LINE_BITS'(diff);

   // stage two: feedback term written back
   assign p     = r2_ff * G;
   assign p_rnd = p + PRW'(rvb_pkg::RND_HALF);
   assign pr    = (LINE_BITS+1)'(p_rnd >>> rvb_pkg::ROUND_SHIFT);
   assign wsum  = SW'(pr) + SW'(x2_ff);
   assign wval  = (wsum > LMAX) ? LINE_BITS'(LMAX) :
                  (wsum < LMIN) ? LINE_BITS'(LMIN) : LINE_BITS'(wsum);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         hit1_ff <= 1'b0;
         hit2_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         hit1_ff <= in_valid && v1_ff && (a1_ff == pos_ff);
         hit2_ff <= in_valid && v2_ff && (a2_ff == pos_ff);
         if (in_valid) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= pos_ff;
         a2_ff  <= a1_ff;
         x1_ff  <= x;
         x2_ff  <= x1_ff;
         m_ff   <= x * G;
         r2_ff  <= r;
         fwd_ff <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= mem[pos_ff];
      end
      if (clr_en) begin
         mem[clr_addr] <= '0;
      end else if (en && v2_ff) begin
         mem[a2_ff] <= wval;
      end
   end

   assign r_out = r2_ff;

endmodule
`default_nettype wire

### design/schroeder_reverb_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// req_      in         req_tvalid/tready    req_tdata: sample_in
// rsp_      out        rsp_tvalid/tready    rsp_tdata: sample_out
// csr_      in         csr_we               csr_addr, csr_wdata
//
// one item per cycle while the output is not stalled; an accepted item passes the comb and
// allpass read-modify-write loops (two stages each) and mixing before the output register.
// after reset a clearing pass zeroes all delay memories, one address a cycle, over
// max(COMB_DEPTH, ALLPASS_DEPTH) entries (8192 by default); req_tready stays low meanwhile.
// the whole pipeline advances whenever the output register is empty or being taken.
module schroeder_reverb_top #(
   parameter int COMB_DEPTH    = rvb_pkg::COMB_DEPTH_DEF,
   parameter int ALLPASS_DEPTH = rvb_pkg::ALLPASS_DEPTH_DEF,
   parameter int SAMPLE_BITS   = rvb_pkg::SAMPLE_BITS_DEF,
   parameter int LINE_BITS     = rvb_pkg::LINE_BITS_DEF,
   localparam int DATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [DATA_W-1:0]                 req_tdata,  // sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [DATA_W-1:0]                 rsp_tdata,  // sample_out
   input  logic                              csr_we,
   input  logic [rvb_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rvb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NC      = rvb_pkg::NUM_COMB;
   localparam int NA      = rvb_pkg::NUM_AP;
   localparam int PW_C    = $clog2(COMB_DEPTH);
   localparam int PW_A    = $clog2(ALLPASS_DEPTH);
   localparam int CLR_N   = (COMB_DEPTH > ALLPASS_DEPTH) ? COMB_DEPTH : ALLPASS_DEPTH;
   localparam int CW      = $clog2(CLR_N);
   localparam int LAST    = 10;
   localparam int SUMW    = LINE_BITS + 3;
   localparam int WPW     = LINE_BITS + rvb_pkg::GAIN_W + 1;
   localparam int OW      = ((LINE_BITS + 2 > SAMPLE_BITS) ? LINE_BITS + 2 : SAMPLE_BITS) + 1;
   localparam logic signed [OW-1:0] SMAX = {{(OW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [OW-1:0] SMIN = {{(OW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic [rvb_pkg::LEVEL_W-1:0] level_ff;
   logic [rvb_pkg::CLEN_W-1:0]  comb_len_ff [NC];
   logic [rvb_pkg::ALEN_W-1:0]  ap_len_ff [NA];
   logic [rvb_pkg::GAIN_W-1:0]  lvl_gain_ff;

   logic          clearing_ff;
   logic [CW-1:0] clr_cnt_ff;

   logic                          en, acc;
   logic                          vld_ff [1:LAST];
   logic signed [SAMPLE_BITS-1:0] dry_ff [1:LAST];
   logic signed [SAMPLE_BITS-1:0] dry_in;
   logic signed [LINE_BITS-1:0]   rb [NC];
   logic signed [LINE_BITS-1:0]   ap_x [NA+1];
   logic signed [SUMW-1:0]        sum;
   logic signed [LINE_BITS-1:0]   x3_ff;
   logic signed [WPW-1:0]         wet_ff, wet_rnd;
   logic signed [LINE_BITS+1:0]   wet;
   logic signed [OW-1:0]          osum;
   logic [SAMPLE_BITS-1:0]        out_ff;
   logic                          rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && !clearing_ff;
   assign acc        = req_tvalid && req_tready;
   assign dry_in     = $signed(req_tdata[SAMPLE_BITS-1:0]);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         comb_len_ff <= rvb_pkg::COMB_LEN_RST;
         ap_len_ff   <= rvb_pkg::AP_LEN_RST;
         lvl_gain_ff <= '0;
      end else begin
         lvl_gain_ff <= rvb_pkg::level_gain(level_ff);
         if (csr_we) begin
            unique case (csr_addr) inside
               rvb_pkg::REG_LEVEL: begin
                  level_ff <= csr_wdata[rvb_pkg::LEVEL_W-1:0];
               end
               [rvb_pkg::REG_COMB0:rvb_pkg::REG_COMB3]: begin
                  comb_len_ff[2'(csr_addr - rvb_pkg::REG_COMB0)] <= csr_wdata;
               end
               [rvb_pkg::REG_AP0:rvb_pkg::REG_AP2]: begin
                  ap_len_ff[2'(csr_addr - rvb_pkg::REG_AP0)] <=
                     csr_wdata[rvb_pkg::ALEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // memory clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + CW'(1);
         if (clr_cnt_ff == CW'(CLR_N - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < NC; i++) begin : g_comb
      rvb_comb #(
         .DEPTH       (COMB_DEPTH),
         .SAMPLE_BITS (SAMPLE_BITS),
         .LINE_BITS   (LINE_BITS)
      ) u_comb (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (acc),
         .dry      (dry_in),
         .len      (comb_len_ff[i]),
         .gain     (rvb_pkg::COMB_GAIN[i]),
         .clr_en   (clearing_ff),
         .clr_addr (clr_cnt_ff[PW_C-1:0]),
         .rb_out   (rb[i])
      );
   end

   // quarter of the comb sum, rounded half up
   assign sum = SUMW'(rb[0]) + SUMW'(rb[1]) + SUMW'(rb[2]) + SUMW'(rb[3]) + SUMW'(2);
   assign ap_x[0] = x3_ff;

   for (genvar i = 0; i < NA; i++) begin : g_ap
      rvb_allpass #(
         .DEPTH     (ALLPASS_DEPTH),
         .LINE_BITS (LINE_BITS)
      ) u_ap (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (vld_ff[3 + 2 * i]),
         .x        (ap_x[i]),
         .len      (ap_len_ff[i]),
         .clr_en   (clearing_ff),
         .clr_addr (clr_cnt_ff[PW_A-1:0]),
         .r_out    (ap_x[i + 1])
      );
   end

   assign wet_rnd = wet_ff + WPW'(rvb_pkg::RND_HALF);
   assign wet     = (LINE_BITS+2)'(wet_rnd >>> rvb_pkg::ROUND_SHIFT);
   assign osum    = OW'(dry_ff[LAST]) + OW'(wet);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '{default: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= acc;
         for (int k = 2; k <= LAST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dry_ff[1] <= dry_in;
         for (int k = 2; k <= LAST; k++) begin
            dry_ff[k] <= dry_ff[k-1];
         end
         x3_ff  <= LINE_BITS'(sum >>> 2);
         wet_ff <= ap_x[NA] * $signed({1'b0, lvl_gain_ff});
         if (osum > SMAX) begin
            out_ff <= SAMPLE_BITS'(SMAX);
         end else if (osum < SMIN) begin
            out_ff <= SAMPLE_BITS'(SMIN);
         end else begin
            out_ff <= SAMPLE_BITS'(osum);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(out_ff);

endmodule
`default_nettype wire
